// ----- rtl/core/wrg_pkg.sv -----
// ----------------------------------------------------------------------------
// wrg_pkg
// Shared types and frame type codes for the roam gap monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package wrg_pkg;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SEQ_W  = 12;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned CHAN_W = 16;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned GAP_W  = 64;
  localparam int unsigned MAP_W  = 64;
  localparam int unsigned FTYPE_W = 6;

  // frame type is {fc[3:2], fc[7:4]}
  localparam logic [FTYPE_W-1:0] FTYPE_DATA      = 6'h20;
  localparam logic [FTYPE_W-1:0] FTYPE_QOS_DATA  = 6'h28;
  localparam logic [FTYPE_W-1:0] FTYPE_ACK       = 6'h1d;
  localparam logic [FTYPE_W-1:0] FTYPE_BLOCK_ACK = 6'h19;

  typedef struct packed {
    logic [7:0]        frame_control_low;
    logic [ADDR_W-1:0] receiver_address;
    logic [ADDR_W-1:0] transmitter_address;
    logic [15:0]       sequence_control;
    logic [15:0]       block_ack_start;
    logic [MAP_W-1:0]  block_ack_bitmap;
    logic [TIME_W-1:0] capture_time_us;
    logic [CHAN_W-1:0] channel_mhz;
  } frame_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       old_access_point;
    logic [ADDR_W-1:0]       new_access_point;
    logic [NUM_W-1:0]        old_frame_number;
    logic [NUM_W-1:0]        new_frame_number;
    logic signed [GAP_W-1:0] gap_us;
    logic [CHAN_W-1:0]       old_channel_mhz;
    logic [CHAN_W-1:0]       new_channel_mhz;
  } roam_rec_t;

endpackage

`default_nettype wire

// ----- rtl/core/wrg_in_reg.sv -----
// ----------------------------------------------------------------------------
// wrg_in_reg
// Input register: holds one frame header until the tracker consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_in_reg (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wrg_pkg::frame_t  frame_in,
  input  wire              consume,
  output logic             full,
  output wrg_pkg::frame_t  frame
);

  // a transfer can land in the same cycle the held frame is consumed
  assign in_ready = !full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (consume) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame <= frame_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wrg_track.sv -----
// ----------------------------------------------------------------------------
// wrg_track
// Ack tracking state and roam detection, one frame per consume.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_track #(
  parameter int unsigned BITMAP_BITS = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [wrg_pkg::ADDR_W-1:0]    cfg_addr,
  input  wire                          consume,
  input  wrg_pkg::frame_t              frame,
  output logic                         rec_valid,
  output wrg_pkg::roam_rec_t           rec
);

  localparam logic [wrg_pkg::SEQ_W-1:0] WINDOW = wrg_pkg::SEQ_W'(BITMAP_BITS);

  logic [wrg_pkg::ADDR_W-1:0] station_address;

  logic                       awaiting_ack;
  logic [wrg_pkg::ADDR_W-1:0] held_transmitter;
  logic [wrg_pkg::ADDR_W-1:0] held_peer;
  logic [wrg_pkg::SEQ_W-1:0]  held_sequence;
  logic [wrg_pkg::TIME_W-1:0] held_time;
  logic [wrg_pkg::CHAN_W-1:0] held_channel;
  logic [wrg_pkg::ADDR_W-1:0] previous_peer;
  logic [wrg_pkg::CHAN_W-1:0] previous_channel;
  logic [wrg_pkg::TIME_W-1:0] previous_time;
  logic [wrg_pkg::NUM_W-1:0]  previous_acked_number;
  logic                       roam_seen;
  logic [wrg_pkg::NUM_W-1:0]  frame_counter;

  logic [wrg_pkg::FTYPE_W-1:0] ftype;
  logic [wrg_pkg::NUM_W-1:0]   count;
  logic [wrg_pkg::SEQ_W-1:0]   offset;
  logic                        acked;
  logic                        peer_change;
  logic                        ra_match;
  logic                        ta_match;
  logic                        capture;

  always_comb begin
    ftype    = {frame.frame_control_low[3:2], frame.frame_control_low[7:4]};
    count    = frame_counter + 1'b1;
    offset   = held_sequence - frame.block_ack_start[15:4];
    ra_match = (frame.receiver_address == station_address);
    ta_match = (frame.transmitter_address == station_address);
    acked    = 1'b0;
    if (frame.receiver_address == held_transmitter) begin
      if (ftype == wrg_pkg::FTYPE_ACK) begin
        acked = 1'b1;
      end else if (ftype == wrg_pkg::FTYPE_BLOCK_ACK && offset < WINDOW) begin
        acked = frame.block_ack_bitmap[offset[5:0]];
      end
    end
    peer_change = (previous_peer != held_peer);
    capture     = !awaiting_ack && (ra_match || ta_match) &&
                  (ftype == wrg_pkg::FTYPE_DATA || ftype == wrg_pkg::FTYPE_QOS_DATA);

    rec_valid = awaiting_ack && acked && peer_change && roam_seen;
    rec.old_access_point = previous_peer;
    rec.new_access_point = held_peer;
    rec.old_frame_number = previous_acked_number - 1'b1;
    rec.new_frame_number = frame_counter;
    rec.gap_us           = {1'b0, held_time} - {1'b0, previous_time};
    rec.old_channel_mhz  = previous_channel;
    rec.new_channel_mhz  = held_channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= '0;
    end else if (cfg_we) begin
      station_address <= cfg_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_ack          <= 1'b0;
      roam_seen             <= 1'b0;
      frame_counter         <= '0;
      previous_peer         <= '0;
      previous_channel      <= '0;
      previous_time         <= '0;
      previous_acked_number <= '0;
    end else if (consume) begin
      frame_counter <= count;
      if (awaiting_ack) begin
        awaiting_ack <= 1'b0;
        if (acked) begin
          if (peer_change) begin
            previous_peer <= held_peer;
            roam_seen     <= 1'b1;
          end
          previous_acked_number <= count;
          previous_channel      <= held_channel;
          previous_time         <= held_time;
        end
      end else if (capture) begin
        awaiting_ack <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume && capture) begin
      held_peer        <= ta_match ? frame.receiver_address : frame.transmitter_address;
      held_transmitter <= frame.transmitter_address;
      held_sequence    <= frame.sequence_control[15:4];
      held_time        <= frame.capture_time_us;
      held_channel     <= frame.channel_mhz;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wrg_out_reg.sv -----
// ----------------------------------------------------------------------------
// wrg_out_reg
// Result register for roam records.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_out_reg (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 load,
  input  wire                 load_valid,
  input  wrg_pkg::roam_rec_t  rec_in,
  input  wire                 out_ready,
  output logic                out_valid,
  output wrg_pkg::roam_rec_t  rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      rec <= rec_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wlan_roam_gap_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// wlan_roam_gap_monitor_unit
// Roam detector over captured 802.11 frame headers for one station.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: station_address is written on a cfg_valid/cfg_ready transfer;
//   cfg_ready is always high. Write only while no frame is in flight.
//   in channel: one frame header per in_valid/in_ready transfer.
//   out channel: one roam record per out_valid/out_ready transfer; most
//   frames give no record.
// Path: the acknowledging frame enters the input register at its transfer;
//   its record is taken into the result register, which raises out_valid,
//   once that register is free or draining.
// Throughput: one frame per cycle while no record stalls; the ack check,
//   bitmap select and gap subtraction sit between input and result registers.
// Stall: while a record waits on out_ready, the input register holds one
//   more frame and then in_ready drops.
// Reset: rst clears the station address, the tracking state and both
//   registers' valid flags; no record is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module wlan_roam_gap_monitor_unit #(
  parameter int unsigned BITMAP_BITS = 64
) (
  input  wire                clk,
  input  wire                rst,

  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [47:0]        station_address,

  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [7:0]         frame_control_low,
  input  wire  [47:0]        receiver_address,
  input  wire  [47:0]        transmitter_address,
  input  wire  [15:0]        sequence_control,
  input  wire  [15:0]        block_ack_start,
  input  wire  [63:0]        block_ack_bitmap,
  input  wire  [62:0]        capture_time_us,
  input  wire  [15:0]        channel_mhz,

  output logic               out_valid,
  input  wire                out_ready,
  output logic [47:0]        old_access_point,
  output logic [47:0]        new_access_point,
  output logic [31:0]        old_frame_number,
  output logic [31:0]        new_frame_number,
  output logic signed [63:0] gap_us,
  output logic [15:0]        old_channel_mhz,
  output logic [15:0]        new_channel_mhz
);

  wrg_pkg::frame_t    frame_in;
  wrg_pkg::frame_t    frame;
  wrg_pkg::roam_rec_t rec_next;
  wrg_pkg::roam_rec_t rec;
  logic               in_full;
  logic               consume;
  logic               rec_valid;

  assign cfg_ready = 1'b1;

  assign frame_in.frame_control_low   = frame_control_low;
  assign frame_in.receiver_address    = receiver_address;
  assign frame_in.transmitter_address = transmitter_address;
  assign frame_in.sequence_control    = sequence_control;
  assign frame_in.block_ack_start     = block_ack_start;
  assign frame_in.block_ack_bitmap    = block_ack_bitmap;
  assign frame_in.capture_time_us     = capture_time_us;
  assign frame_in.channel_mhz         = channel_mhz;

  // process the held frame when the result register is free or draining
  assign consume = in_full && (!out_valid || out_ready);

  wrg_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .frame_in (frame_in),
    .consume  (consume),
    .full     (in_full),
    .frame    (frame)
  );

  wrg_track #(
    .BITMAP_BITS (BITMAP_BITS)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_addr  (station_address),
    .consume   (consume),
    .frame     (frame),
    .rec_valid (rec_valid),
    .rec       (rec_next)
  );

  wrg_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (consume),
    .load_valid (rec_valid),
    .rec_in     (rec_next),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .rec        (rec)
  );

  assign old_access_point = rec.old_access_point;
  assign new_access_point = rec.new_access_point;
  assign old_frame_number = rec.old_frame_number;
  assign new_frame_number = rec.new_frame_number;
  assign gap_us           = rec.gap_us;
  assign old_channel_mhz  = rec.old_channel_mhz;
  assign new_channel_mhz  = rec.new_channel_mhz;

  // a stalled input side means a frame is held
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full)
    else $error("in_ready low with empty input register");

  // a roam record always names two different access points
  a_rec_distinct: assert property (@(posedge clk) disable iff (rst)
    consume && rec_valid |=> out_valid && (old_access_point != new_access_point))
    else $error("roam record with equal access points");

  // a record is never dropped while waiting on the receiver
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !consume)
    else $error("result register overwritten while stalled");

  // a record loaded on a consume carries two distinct frame numbers
  a_rec_numbers: assert property (@(posedge clk) disable iff (rst)
    consume && rec_valid |=> (new_frame_number != old_frame_number))
    else $error("roam record frame numbers collide");

endmodule

`default_nettype wire

// ----- test/tb_wlan_roam_gap_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// tb_wlan_roam_gap_monitor_unit
// Self-checking bench for the roam gap monitor. Frame headers are sent from a
// queue while a local tracker predicts every roam record. Records are compared
// field by field in arrival order. The bench steps through several station
// addresses, uses random idling on both channels and holds off the receiver
// for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wlan_roam_gap_monitor_unit;

  localparam int WINDOW_BITS = wrg_pkg::MAP_W;

  typedef enum int {
    FLAW_NONE,
    FLAW_WRONG_RA,
    FLAW_WRONG_TYPE,
    FLAW_BIT_CLEAR,
    FLAW_OUT_OF_WINDOW
  } flaw_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [47:0]        cfg_station = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  wrg_pkg::frame_t    in_frame = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  wrg_pkg::roam_rec_t out_rec;

  wlan_roam_gap_monitor_unit u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .station_address     (cfg_station),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .frame_control_low   (in_frame.frame_control_low),
    .receiver_address    (in_frame.receiver_address),
    .transmitter_address (in_frame.transmitter_address),
    .sequence_control    (in_frame.sequence_control),
    .block_ack_start     (in_frame.block_ack_start),
    .block_ack_bitmap    (in_frame.block_ack_bitmap),
    .capture_time_us     (in_frame.capture_time_us),
    .channel_mhz         (in_frame.channel_mhz),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .old_access_point    (out_rec.old_access_point),
    .new_access_point    (out_rec.new_access_point),
    .old_frame_number    (out_rec.old_frame_number),
    .new_frame_number    (out_rec.new_frame_number),
    .gap_us              (out_rec.gap_us),
    .old_channel_mhz     (out_rec.old_channel_mhz),
    .new_channel_mhz     (out_rec.new_channel_mhz)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wrg_pkg::frame_t    pending_frames[$];
  wrg_pkg::roam_rec_t expected_roams[$];

  int mismatches = 0;
  int frames_taken = 0;
  int records_seen = 0;
  int station_writes = 0;
  int idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_taken = 1'b0;
  bit cfg_done = 1'b0;
  bit hold_wanted = 1'b0;
  bit hold_off = 1'b0;

  // stimulus side view of the setup
  logic [47:0] cur_station = '0;
  logic [47:0] ap_pool[4];
  logic [15:0] ap_chan[4];
  int          cur_ap = 0;
  logic [62:0] now_us = '0;

  // roam tracker state
  logic [47:0] watched_station = '0;
  logic        awaiting_ack = 1'b0;
  logic [47:0] held_ta = '0;
  logic [47:0] held_peer = '0;
  logic [11:0] held_seq = '0;
  logic [62:0] held_time = '0;
  logic [15:0] held_chan = '0;
  logic [47:0] last_peer = '0;
  logic [15:0] last_chan = '0;
  logic [62:0] last_time = '0;
  logic [31:0] prev_ack_number = '0;
  logic        roam_seen = 1'b0;
  logic [31:0] frame_count = '0;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] fc_for(logic [wrg_pkg::FTYPE_W-1:0] ftype);
    logic [1:0] version;
    version = 2'($urandom_range(0, 3));
    return {ftype[3:0], ftype[5:4], version};
  endfunction

  function automatic wrg_pkg::frame_t random_frame();
    wrg_pkg::frame_t f;
    f.frame_control_low   = 8'($urandom);
    f.receiver_address    = 48'(rand64());
    f.transmitter_address = 48'(rand64());
    f.sequence_control    = 16'($urandom);
    f.block_ack_start     = 16'($urandom);
    f.block_ack_bitmap    = rand64();
    f.capture_time_us     = 63'(rand64());
    f.channel_mhz         = 16'($urandom);
    return f;
  endfunction

  function automatic void clear_tracker();
    watched_station = '0;
    awaiting_ack    = 1'b0;
    last_peer       = '0;
    last_chan       = '0;
    last_time       = '0;
    prev_ack_number = '0;
    roam_seen       = 1'b0;
    frame_count     = '0;
  endfunction

  // one frame through the tracker; a roam record goes to expected_roams
  function automatic void track_frame(wrg_pkg::frame_t f);
    logic [wrg_pkg::FTYPE_W-1:0] ftype;
    logic [31:0]                 count;
    logic [11:0]                 offset;
    logic                        acked;
    wrg_pkg::roam_rec_t          rec;
    ftype = {f.frame_control_low[3:2], f.frame_control_low[7:4]};
    count = frame_count + 32'd1;
    frame_count = count;
    if (awaiting_ack) begin
      awaiting_ack = 1'b0;
      acked = 1'b0;
      if (f.receiver_address == held_ta) begin
        if (ftype == wrg_pkg::FTYPE_ACK) begin
          acked = 1'b1;
        end else if (ftype == wrg_pkg::FTYPE_BLOCK_ACK) begin
          offset = held_seq - f.block_ack_start[15:4];
          acked = (offset < WINDOW_BITS) && f.block_ack_bitmap[offset[5:0]];
        end
      end
      if (acked) begin
        if (last_peer != held_peer) begin
          if (roam_seen) begin
            rec.old_access_point = last_peer;
            rec.new_access_point = held_peer;
            rec.old_frame_number = prev_ack_number - 32'd1;
            rec.new_frame_number = count - 32'd1;
            rec.gap_us           = {1'b0, held_time} - {1'b0, last_time};
            rec.old_channel_mhz  = last_chan;
            rec.new_channel_mhz  = held_chan;
            expected_roams.push_back(rec);
          end
          last_peer = held_peer;
          roam_seen = 1'b1;
        end
        prev_ack_number = count;
        last_chan       = held_chan;
        last_time       = held_time;
      end
    end else if ((ftype == wrg_pkg::FTYPE_DATA || ftype == wrg_pkg::FTYPE_QOS_DATA) &&
                 (f.receiver_address == watched_station ||
                  f.transmitter_address == watched_station)) begin
      held_peer = (f.transmitter_address == watched_station) ?
                  f.receiver_address : f.transmitter_address;
      held_ta      = f.transmitter_address;
      held_seq     = f.sequence_control[15:4];
      held_time    = f.capture_time_us;
      held_chan    = f.channel_mhz;
      awaiting_ack = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: config and frame transfers feed the tracker, records are checked
  always @(posedge clk) begin
    wrg_pkg::roam_rec_t want;
    if (rst) begin
      clear_tracker();
    end else begin
      if (cfg_valid && cfg_ready) begin
        watched_station = cfg_station;
        cfg_done = 1'b1;
        station_writes++;
      end
      if (in_valid && in_ready) begin
        track_frame(in_frame);
        in_taken = 1'b1;
        frames_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_roams.size() == 0) begin
          $error("roam record with none expected: %h", out_rec);
          mismatches++;
        end else begin
          want = expected_roams.pop_front();
          check_field("old_access_point", 64'(want.old_access_point),
                      64'(out_rec.old_access_point));
          check_field("new_access_point", 64'(want.new_access_point),
                      64'(out_rec.new_access_point));
          check_field("old_frame_number", 64'(want.old_frame_number),
                      64'(out_rec.old_frame_number));
          check_field("new_frame_number", 64'(want.new_frame_number),
                      64'(out_rec.new_frame_number));
          check_field("gap_us", want.gap_us, out_rec.gap_us);
          check_field("old_channel_mhz", 64'(want.old_channel_mhz),
                      64'(out_rec.old_channel_mhz));
          check_field("new_channel_mhz", 64'(want.new_channel_mhz),
                      64'(out_rec.new_channel_mhz));
          records_seen++;
        end
      end
    end
  end

  // driver: next frame once the current one is transferred
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_frames.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        in_gap = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else begin
        in_frame <= pending_frames.pop_front();
        in_valid <= 1'b1;
      end
    end
    in_taken = 1'b0;
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_gap = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // once a record is pending, block the output while frames keep coming
  initial begin
    wait (hold_wanted);
    while (expected_roams.size() == 0) @(posedge clk);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic write_station(input logic [47:0] addr);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    cfg_station <= addr;
    cur_station = addr;
    @(negedge clk);
    while (!cfg_done) @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_done = 1'b0;
  endtask

  // wait for an idle block; a trailing frame may still be in the pipeline
  task automatic settle();
    while (pending_frames.size() != 0 || in_valid) @(posedge clk);
    while (expected_roams.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_access_points();
    for (int i = 0; i < 4; i++) begin
      ap_pool[i] = 48'(rand64());
      ap_chan[i] = 16'($urandom);
    end
  endtask

  task automatic push_data(input logic [wrg_pkg::FTYPE_W-1:0] ftype,
                           input logic [47:0] ra,
                           input logic [47:0] ta, input logic [15:0] seq,
                           input logic [62:0] stamp, input logic [15:0] chan);
    wrg_pkg::frame_t f;
    f = random_frame();
    f.frame_control_low   = fc_for(ftype);
    f.receiver_address    = ra;
    f.transmitter_address = ta;
    f.sequence_control    = seq;
    f.capture_time_us     = stamp;
    f.channel_mhz         = chan;
    pending_frames.push_back(f);
  endtask

  task automatic push_ack(input logic [47:0] ra);
    wrg_pkg::frame_t f;
    f = random_frame();
    f.frame_control_low = fc_for(wrg_pkg::FTYPE_ACK);
    f.receiver_address  = ra;
    pending_frames.push_back(f);
  endtask

  task automatic push_block_ack(input logic [47:0] ra, input logic [15:0] start,
                                input logic [63:0] bitmap);
    wrg_pkg::frame_t f;
    f = random_frame();
    f.frame_control_low = fc_for(wrg_pkg::FTYPE_BLOCK_ACK);
    f.receiver_address  = ra;
    f.block_ack_start   = start;
    f.block_ack_bitmap  = bitmap;
    pending_frames.push_back(f);
  endtask

  task automatic directed_frames();
    logic [47:0] s;
    logic [47:0] a;
    logic [47:0] b;
    logic [47:0] c;
    wrg_pkg::frame_t f;
    s = cur_station;
    a = ap_pool[0];
    b = ap_pool[1];
    c = ap_pool[2];
    // a zero peer matches the cleared previous peer, so no change
    push_data(wrg_pkg::FTYPE_DATA, 48'h0, s, 16'h0010, 63'd100, 16'd2412);
    push_ack(s);
    // first change only records the access point
    push_data(wrg_pkg::FTYPE_QOS_DATA, s, a, 16'h0020, 63'd200, 16'd2437);
    push_ack(a);
    // block ack at the window start gives the first roam
    push_data(wrg_pkg::FTYPE_QOS_DATA, b, s, 16'h1230, 63'd900, 16'd5180);
    push_block_ack(s, 16'h1230, 64'h1);
    // offset of 64 falls outside the window
    push_data(wrg_pkg::FTYPE_DATA, a, s, 16'h0400, 63'd1000, 16'd2412);
    push_block_ack(s, 16'h0000, '1);
    // last window bit, time running backward
    push_data(wrg_pkg::FTYPE_DATA, a, s, 16'h03f5, 63'd50, 16'd2412);
    push_block_ack(s, 16'h0007, 64'h8000_0000_0000_0000);
    // ack to the wrong address
    push_data(wrg_pkg::FTYPE_DATA, c, s, 16'h0060, 63'd3000, 16'd5500);
    push_ack(s ^ 48'h1);
    // a data frame in the ack slot is neither an ack nor held
    push_data(wrg_pkg::FTYPE_DATA, c, s, 16'h0070, 63'd3100, 16'd5500);
    push_data(wrg_pkg::FTYPE_DATA, s, c, 16'h0080, 63'd3200, 16'd5500);
    // station on both sides: the receiver is the peer
    push_data(wrg_pkg::FTYPE_DATA, s, s, 16'h0050, 63'd5000, 16'd5200);
    push_ack(s);
    // largest capture time and channel
    push_data(wrg_pkg::FTYPE_QOS_DATA, s, c, 16'hfff0, '1, 16'hffff);
    push_ack(c);
    // block ack offset wraps around the sequence space
    push_data(wrg_pkg::FTYPE_DATA, a, s, 16'h0050, 63'd0, 16'd0);
    push_block_ack(s, 16'hffa0, 64'h800);
    // management frame from the station is ignored, so is the ack after it
    f = random_frame();
    f.frame_control_low   = 8'h00;
    f.receiver_address    = a;
    f.transmitter_address = s;
    pending_frames.push_back(f);
    push_ack(s);
    f = '1;
    pending_frames.push_back(f);
    f = '0;
    pending_frames.push_back(f);
  endtask

  task automatic add_exchange();
    wrg_pkg::frame_t d;
    wrg_pkg::frame_t a;
    logic [11:0] held;
    int offset;
    flaw_e flaw;
    if ($urandom_range(0, 3) == 0) cur_ap = $urandom_range(0, 3);
    if ($urandom_range(0, 49) == 0) now_us = 63'(rand64());
    else now_us = now_us + 63'($urandom_range(1, 50000));
    d = random_frame();
    d.frame_control_low = fc_for($urandom_range(0, 1) ? wrg_pkg::FTYPE_DATA :
                                                         wrg_pkg::FTYPE_QOS_DATA);
    if ($urandom_range(0, 1)) begin
      d.receiver_address    = ap_pool[cur_ap];
      d.transmitter_address = cur_station;
    end else begin
      d.receiver_address    = cur_station;
      d.transmitter_address = ap_pool[cur_ap];
    end
    d.capture_time_us = now_us;
    d.channel_mhz     = ap_chan[cur_ap];
    held = d.sequence_control[15:4];
    offset = $urandom_range(0, WINDOW_BITS - 1);
    a = random_frame();
    a.receiver_address = d.transmitter_address;
    if ($urandom_range(0, 1)) begin
      a.frame_control_low = fc_for(wrg_pkg::FTYPE_ACK);
    end else begin
      a.frame_control_low = fc_for(wrg_pkg::FTYPE_BLOCK_ACK);
      a.block_ack_start[15:4] = held - 12'(offset);
      a.block_ack_bitmap[offset] = 1'b1;
    end
    flaw = ($urandom_range(0, 5) == 0) ? flaw_e'($urandom_range(1, 4)) : FLAW_NONE;
    case (flaw)
      FLAW_WRONG_RA: begin
        a.receiver_address = a.receiver_address ^ (48'd1 << $urandom_range(0, 47));
      end
      FLAW_WRONG_TYPE: begin
        a.frame_control_low = fc_for(wrg_pkg::FTYPE_DATA);
      end
      FLAW_BIT_CLEAR: begin
        a.frame_control_low = fc_for(wrg_pkg::FTYPE_BLOCK_ACK);
        a.block_ack_start[15:4] = held - 12'(offset);
        a.block_ack_bitmap[offset] = 1'b0;
      end
      FLAW_OUT_OF_WINDOW: begin
        a.frame_control_low = fc_for(wrg_pkg::FTYPE_BLOCK_ACK);
        a.block_ack_start[15:4] = held - 12'($urandom_range(WINDOW_BITS, 4095));
        a.block_ack_bitmap = '1;
      end
      default: ;
    endcase
    pending_frames.push_back(d);
    pending_frames.push_back(a);
  endtask

  task automatic add_traffic(input int count);
    int made;
    wrg_pkg::frame_t f;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 9))
        0: begin
          pending_frames.push_back(random_frame());
        end
        1: begin
          // data frame with no ack behind it
          f = random_frame();
          f.frame_control_low   = fc_for(wrg_pkg::FTYPE_QOS_DATA);
          f.transmitter_address = cur_station;
          pending_frames.push_back(f);
          made++;
        end
        default: begin
          add_exchange();
          made += 2;
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_pct = 20;
    pick_access_points();
    write_station(48'(rand64()));
    directed_frames();
    settle();

    idle_pct = 30;
    pick_access_points();
    write_station('0);
    add_traffic(150);
    settle();

    idle_pct = 10;
    write_station('1);
    hold_wanted = 1'b1;
    add_traffic(150);
    settle();

    idle_pct = 25;
    pick_access_points();
    write_station(48'(rand64()));
    add_traffic(150);
    settle();

    // closing stretch at full rate
    idle_pct = 0;
    add_traffic(100);
    settle();
    repeat (8) @(posedge clk);

    mismatches += expected_roams.size();
    $display("%0d frames over %0d station addresses, %0d roam records compared",
             frames_taken, station_writes, records_seen);
    if (mismatches == 0) begin
      $display("tb_wlan_roam_gap_monitor_unit: clean");
    end else begin
      $display("tb_wlan_roam_gap_monitor_unit: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_wlan_roam_gap_monitor_unit: errors");
    $finish;
  end

endmodule
